// ----- rtl/assert_macros.svh -----
// Assertion macros for the spanning tree block.
// Used by the top level only; needs a clock named i_clk and a reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bfs_pkg.sv -----
// Shared types and constants for the breadth-first spanning tree block.
// No dependencies; imported by the controller, the datapath and the top level.
package bfs_pkg;

    localparam int VW               = 7;
    localparam int ROW_W            = 64;
    localparam int DEF_MAX_VERTICES = 64;

    typedef enum logic [1:0] {
        ST_ACK      = 2'd0,
        ST_EDGE     = 2'd1,
        ST_NOT_CONN = 2'd2
    } t_result_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_NEXTQ,
        S_EMIT_RD,
        S_EMIT_WAIT
    } t_state;

    typedef struct packed {
        logic load_row;
        logic start;
        logic scan_step;
        logic q_rd;
        logic adj_next;
        logic emit_rd;
        logic out_ack;
        logic out_nc;
        logic out_edge;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic root_ok;
        logic pending_any;
        logic queue_more;
        logic tree_full;
        logic edges_none;
        logic emit_last;
    } t_dp_status;

endpackage

// ----- rtl/bfs_ctrl.sv -----
// Sequencer for load, search and edge emission.
// Depends on bfs_pkg; drives datapath commands from its status.
module bfs_ctrl
    import bfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_kind,
    input  t_dp_status i_sts,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE) && i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_in_kind && i_sts.root_ok) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.pending_any) begin
                    n_state = S_SCAN;
                end else if (i_sts.queue_more) begin
                    n_state = S_NEXTQ;
                end else if (i_sts.tree_full) begin
                    n_state = i_sts.edges_none ? S_IDLE : S_EMIT_RD;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_NEXTQ:   n_state = S_SCAN;
            S_EMIT_RD: n_state = S_EMIT_WAIT;
            S_EMIT_WAIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = !i_sts.out_free;
                if (w_accept) begin
                    if (!i_in_kind) begin
                        o_cmd.load_row = 1'b1;
                        o_cmd.out_ack  = 1'b1;
                    end else if (i_sts.root_ok) begin
                        o_cmd.start    = 1'b1;
                    end else begin
                        o_cmd.out_nc   = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.pending_any) begin
                    o_cmd.scan_step = 1'b1;
                end else if (i_sts.queue_more) begin
                    o_cmd.q_rd = 1'b1;
                end else if (!i_sts.tree_full && i_sts.out_free) begin
                    o_cmd.out_nc = 1'b1;
                end
            end
            S_NEXTQ:   o_cmd.adj_next = 1'b1;
            S_EMIT_RD: o_cmd.emit_rd  = 1'b1;
            S_EMIT_WAIT: begin
                o_cmd.out_edge = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/bfs_datapath.sv -----
// Adjacency memory, visited marks, queue and tree edge memory, output register.
// Depends on bfs_pkg; steered by bfs_ctrl commands.
module bfs_datapath
    import bfs_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [VW-1:0]    i_cfg_data,
    input  logic [VW-1:0]    i_in_row_vertex,
    input  logic [ROW_W-1:0] i_in_row_bits,
    input  logic [VW-1:0]    i_in_start_vertex,
    input  logic             i_out_stall,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_sts,
    output logic             o_out_valid,
    output logic [1:0]       o_out_status,
    output logic [VW-1:0]    o_out_parent_vertex,
    output logic [VW-1:0]    o_out_child_vertex,
    output logic             o_out_last
);

    localparam int IW = $clog2(MAX_VERTICES);

    logic [MAX_VERTICES-1:0] m_adj [MAX_VERTICES];
    logic [2*IW-1:0]         m_edge [MAX_VERTICES-1];

    logic [VW-1:0]           r_vcount;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [MAX_VERTICES-1:0] r_adj_q;
    logic [2*IW-1:0]         r_edge_q;
    logic [IW-1:0]           r_cur;
    logic [IW-1:0]           r_edge_cnt;
    logic [IW-1:0]           r_head;
    logic [IW-1:0]           r_emit_idx;

    logic                    r_out_valid;
    t_result_status          r_out_status;
    logic [VW-1:0]           r_out_parent;
    logic [VW-1:0]           r_out_child;
    logic                    r_out_last;

    logic [VW-1:0]           w_n;
    logic [MAX_VERTICES-1:0] w_mask;
    logic [MAX_VERTICES-1:0] w_pending;
    logic [IW-1:0]           w_found;
    logic [IW-1:0]           w_root_idx;
    logic [IW-1:0]           w_row_idx;
    logic                    w_row_ok;
    logic                    w_out_free;
    logic [IW-1:0]           w_adj_raddr;
    logic [IW-1:0]           w_edge_raddr;
    logic                    w_emit_last;

    function automatic logic [IW-1:0] lowest_set(input logic [MAX_VERTICES-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IW'(i);
            end
        end
        return idx;
    endfunction

    always_comb begin
        if (r_vcount == '0) begin
            w_n = VW'(1);
        end else if (r_vcount > VW'(MAX_VERTICES)) begin
            w_n = VW'(MAX_VERTICES);
        end else begin
            w_n = r_vcount;
        end
    end

    always_comb begin
        for (int t = 0; t < MAX_VERTICES; t++) begin
            w_mask[t] = (VW'(t) < w_n);
        end
    end

    assign w_pending    = r_adj_q & ~r_visited & w_mask;
    assign w_found      = lowest_set(w_pending);
    assign w_root_idx   = IW'(i_in_start_vertex - VW'(1));
    assign w_row_idx    = IW'(i_in_row_vertex - VW'(1));
    assign w_row_ok     = (i_in_row_vertex != '0) && (i_in_row_vertex <= VW'(MAX_VERTICES));
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_adj_raddr  = i_cmd.start ? w_root_idx : r_edge_q[IW-1:0];
    assign w_edge_raddr = i_cmd.q_rd ? r_head : r_emit_idx;
    assign w_emit_last  = (r_emit_idx == r_edge_cnt - IW'(1));

    always_comb begin
        o_sts             = '0;
        o_sts.out_free    = w_out_free;
        o_sts.root_ok     = (i_in_start_vertex != '0) && (i_in_start_vertex <= w_n);
        o_sts.pending_any = |w_pending;
        o_sts.queue_more  = (r_head < r_edge_cnt);
        o_sts.tree_full   = (VW'(r_edge_cnt) == w_n - VW'(1));
        o_sts.edges_none  = (w_n == VW'(1));
        o_sts.emit_last   = w_emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_row && w_row_ok) begin
            m_adj[w_row_idx] <= i_in_row_bits[MAX_VERTICES-1:0];
        end
        if (i_cmd.start || i_cmd.adj_next) begin
            r_adj_q <= m_adj[w_adj_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            m_edge[r_edge_cnt] <= {r_cur, w_found};
        end
        if (i_cmd.q_rd || i_cmd.emit_rd) begin
            r_edge_q <= m_edge[w_edge_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= VW'(1);
            r_out_valid <= 1'b0;
            r_edge_cnt  <= '0;
            r_head      <= '0;
            r_emit_idx  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_vcount <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_edge_cnt <= '0;
                r_head     <= '0;
                r_emit_idx <= '0;
            end
            if (i_cmd.scan_step) begin
                r_edge_cnt <= r_edge_cnt + IW'(1);
            end
            if (i_cmd.q_rd) begin
                r_head <= r_head + IW'(1);
            end
            if (i_cmd.out_edge) begin
                r_emit_idx <= r_emit_idx + IW'(1);
            end
            if (i_cmd.out_ack || i_cmd.out_nc || i_cmd.out_edge) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_visited <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << w_root_idx;
            r_cur     <= w_root_idx;
        end
        if (i_cmd.scan_step) begin
            r_visited[w_found] <= 1'b1;
        end
        if (i_cmd.adj_next) begin
            r_cur <= r_edge_q[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ack || i_cmd.out_nc) begin
            r_out_status <= i_cmd.out_ack ? ST_ACK : ST_NOT_CONN;
            r_out_parent <= '0;
            r_out_child  <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.out_edge) begin
            r_out_status <= ST_EDGE;
            r_out_parent <= VW'(r_edge_q[2*IW-1:IW]) + VW'(1);
            r_out_child  <= VW'(r_edge_q[IW-1:0]) + VW'(1);
            r_out_last   <= w_emit_last;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_status        = r_out_status;
    assign o_out_parent_vertex = r_out_parent;
    assign o_out_child_vertex  = r_out_child;
    assign o_out_last          = r_out_last;

endmodule

// ----- rtl/bfs_spanning_tree_unit.sv -----
// Top level of the breadth-first spanning tree block.
// Depends on bfs_pkg, bfs_ctrl, bfs_datapath and assert_macros.svh.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid / o_in_stall kind, row_vertex, row_bits, start_vertex
//   out      output     o_out_valid / i_out_stall status, parent_vertex, child_vertex, last
//   cfg      input      i_cfg_valid / o_cfg_ready vertex_count
//
// A row load returns one ack through the output register. A search makes one
// scan step per discovered vertex and, per dequeued vertex, one queue read and one
// adjacency row read, in turn, set by the single read port of the adjacency and edge
// memories; then each tree edge is read and loaded into the output register when free.
// Reset is synchronous, active low; no clearing pass is needed.
// Output stalls hold the sequencer; inputs are taken only when it is idle.
`include "assert_macros.svh"

module bfs_spanning_tree_unit
    import bfs_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [VW-1:0]    i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_in_kind,
    input  logic [VW-1:0]    i_in_row_vertex,
    input  logic [ROW_W-1:0] i_in_row_bits,
    input  logic [VW-1:0]    i_in_start_vertex,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_out_status,
    output logic [VW-1:0]    o_out_parent_vertex,
    output logic [VW-1:0]    o_out_child_vertex,
    output logic             o_out_last
);

    t_dp_cmd    w_cmd;
    t_dp_status w_sts;

    assign o_cfg_ready = 1'b1;

    bfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_kind),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    bfs_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_in_row_vertex     (i_in_row_vertex),
        .i_in_row_bits       (i_in_row_bits),
        .i_in_start_vertex   (i_in_start_vertex),
        .i_out_stall         (i_out_stall),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .o_out_valid         (o_out_valid),
        .o_out_status        (o_out_status),
        .o_out_parent_vertex (o_out_parent_vertex),
        .o_out_child_vertex  (o_out_child_vertex),
        .o_out_last          (o_out_last)
    );

    `ASSERT_ALWAYS(a_load_when_free, !(w_cmd.out_ack || w_cmd.out_nc || w_cmd.out_edge) || w_sts.out_free, "result loaded over a pending one")
    `ASSERT_ALWAYS(a_one_step, $onehot0({w_cmd.start, w_cmd.scan_step, w_cmd.q_rd, w_cmd.adj_next, w_cmd.emit_rd, w_cmd.out_edge}), "overlapping sequencer commands")
    `ASSERT_ALWAYS(a_scan_has_bit, !w_cmd.scan_step || w_sts.pending_any, "scan step without a new neighbor")
    `ASSERT_NEXT(a_load_acked, i_in_valid && !o_in_stall && !i_in_kind, o_out_valid, "row load without ack")

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for bfs_spanning_tree_unit: directed and random adjacency loads and searches,
// each result checked against a breadth-first predictor kept here. Needs bfs_pkg and the RTL.
module tb_top;
    import bfs_pkg::*;

    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_START    = 1'b1;
    localparam int   IDLE_PCT      = 31;
    localparam int   SETTLE_CYCLES = 400;
    localparam int   HOLD_CYCLES   = 300;
    localparam int   CYCLE_LIMIT   = 1000000;
    localparam int   RANDOM_ITEMS  = 90;
    localparam int   NV            = DEF_MAX_VERTICES;

    typedef struct {
        logic             kind;
        logic [VW-1:0]    row_vertex;
        logic [ROW_W-1:0] row_bits;
        logic [VW-1:0]    start_vertex;
    } t_graph_item;

    typedef struct {
        t_result_status status;
        logic [VW-1:0]  parent;
        logic [VW-1:0]  child;
        logic           last;
    } t_tree_result;

    logic             i_clk             = 1'b0;
    logic             i_rst_n           = 1'b0;
    logic             i_cfg_valid       = 1'b0;
    logic             o_cfg_ready;
    logic [VW-1:0]    i_cfg_data        = '0;
    logic             i_in_valid        = 1'b0;
    logic             o_in_stall;
    logic             i_in_kind         = 1'b0;
    logic [VW-1:0]    i_in_row_vertex   = '0;
    logic [ROW_W-1:0] i_in_row_bits     = '0;
    logic [VW-1:0]    i_in_start_vertex = '0;
    logic             o_out_valid;
    logic             i_out_stall       = 1'b0;
    logic [1:0]       o_out_status;
    logic [VW-1:0]    o_out_parent_vertex;
    logic [VW-1:0]    o_out_child_vertex;
    logic             o_out_last;

    t_graph_item      item_fifo[$];
    t_graph_item      taken_item;
    t_graph_item      next_item;
    t_tree_result     results_due[$];
    t_tree_result     want;
    logic [ROW_W-1:0] adj_rows [NV];
    logic [VW-1:0]    active_vertices = 7'd1;
    logic [ROW_W-1:0] graph_rows [NV];
    int               items_sent;
    int               items_taken;
    int               results_seen;
    int               errors;
    int               cfg_writes;
    int               trees_predicted;
    int               unconnected_predicted;
    int               hold_left;
    int               cycle_count;
    bit               no_idle;
    bit               hold_req;

    bfs_spanning_tree_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_in_kind           (i_in_kind),
        .i_in_row_vertex     (i_in_row_vertex),
        .i_in_row_bits       (i_in_row_bits),
        .i_in_start_vertex   (i_in_start_vertex),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_out_status        (o_out_status),
        .o_out_parent_vertex (o_out_parent_vertex),
        .o_out_child_vertex  (o_out_child_vertex),
        .o_out_last          (o_out_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        errors++;
        if (errors <= 50) begin
            $display("mismatch %s: got %0d, expected %0d (result %0d, cycle %0d)",
                     what, got, exp_val, results_seen, cycle_count);
        end
    endtask

    function automatic void push_result(input t_result_status status, input logic [VW-1:0] parent,
                                        input logic [VW-1:0] child, input logic last);
        t_tree_result r;
        r.status = status;
        r.parent = parent;
        r.child  = child;
        r.last   = last;
        results_due.push_back(r);
    endfunction

    function automatic void predict_tree(input t_graph_item it);
        int unsigned      n;
        int unsigned      head;
        int unsigned      tail;
        int unsigned      found;
        int unsigned      k;
        int unsigned      order [NV];
        logic [NV-1:0]    seen;
        logic [VW-1:0]    par [NV];
        logic [VW-1:0]    chi [NV];
        logic [ROW_W-1:0] row;
        n = (active_vertices == 0) ? 1 : (active_vertices > NV) ? NV : active_vertices;
        if (it.kind == KIND_LOAD) begin
            if (it.row_vertex >= 1 && it.row_vertex <= NV)
                adj_rows[it.row_vertex - 1] = it.row_bits;
            push_result(ST_ACK, '0, '0, 1'b1);
            return;
        end
        if (it.start_vertex < 1 || it.start_vertex > n) begin
            push_result(ST_NOT_CONN, '0, '0, 1'b1);
            unconnected_predicted++;
            return;
        end
        seen = '0;
        order[0] = it.start_vertex - 1;
        seen[order[0]] = 1'b1;
        head = 0;
        tail = 1;
        found = 0;
        while (head < tail) begin
            row = adj_rows[order[head]];
            for (k = 0; k < n; k++) begin
                if (row[k] && !seen[k]) begin
                    seen[k] = 1'b1;
                    order[tail] = k;
                    tail++;
                    par[found] = VW'(order[head] + 1);
                    chi[found] = VW'(k + 1);
                    found++;
                end
            end
            head++;
        end
        if (found < n - 1) begin
            push_result(ST_NOT_CONN, '0, '0, 1'b1);
            unconnected_predicted++;
            return;
        end
        for (k = 0; k < found; k++)
            push_result(ST_EDGE, par[k], chi[k], k + 1 == found);
        if (found != 0)
            trees_predicted++;
    endfunction

    // input channel: accept, predict, then offer the next queued transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                taken_item.kind         = i_in_kind;
                taken_item.row_vertex   = i_in_row_vertex;
                taken_item.row_bits     = i_in_row_bits;
                taken_item.start_vertex = i_in_start_vertex;
                predict_tree(taken_item);
                items_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (item_fifo.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_item = item_fifo.pop_front();
                    i_in_valid        <= 1'b1;
                    i_in_kind         <= next_item.kind;
                    i_in_row_vertex   <= next_item.row_vertex;
                    i_in_row_bits     <= next_item.row_bits;
                    i_in_start_vertex <= next_item.start_vertex;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output channel: check each transaction against the oldest expected result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    report_mismatch("result with nothing outstanding", o_out_status, 0);
                end else begin
                    want = results_due.pop_front();
                    if (o_out_status !== want.status)
                        report_mismatch("status", o_out_status, want.status);
                    if (o_out_parent_vertex !== want.parent)
                        report_mismatch("parent_vertex", o_out_parent_vertex, want.parent);
                    if (o_out_child_vertex !== want.child)
                        report_mismatch("child_vertex", o_out_child_vertex, want.child);
                    if (o_out_last !== want.last)
                        report_mismatch("last", o_out_last, want.last);
                end
            end
        end
    end

    // receiver stall: hold off for a counted stretch on request, else idle at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

    task automatic send_item(input logic kind, input logic [VW-1:0] row_vertex,
                             input logic [ROW_W-1:0] row_bits, input logic [VW-1:0] start_vertex);
        t_graph_item it;
        @(negedge i_clk);
        while (item_fifo.size() >= 2) @(negedge i_clk);
        it.kind         = kind;
        it.row_vertex   = row_vertex;
        it.row_bits     = row_bits;
        it.start_vertex = start_vertex;
        item_fifo.push_back(it);
        items_sent++;
    endtask

    task automatic wait_results();
        while (items_taken != items_sent || results_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [VW-1:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        active_vertices = value;
        cfg_writes++;
    endtask

    task automatic send_graph(input int n, input bit connected, input int starts);
        int               perm [NV];
        int               i;
        int               j;
        int               a;
        int               b;
        int               tmp;
        logic [ROW_W-1:0] span;
        logic [VW-1:0]    root;
        span = (n >= NV) ? '1 : ((64'd1 << n) - 64'd1);
        for (i = 0; i < NV; i++) begin
            graph_rows[i] = '0;
            perm[i] = i;
        end
        for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (i = 1; i < n; i++) begin
            a = perm[i];
            b = perm[$urandom_range(0, i - 1)];
            graph_rows[a][b] = 1'b1;
            graph_rows[b][a] = 1'b1;
        end
        repeat ($urandom_range(0, n)) begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            graph_rows[a][b] = 1'b1;
            graph_rows[b][a] = 1'b1;
        end
        if (!connected && n > 1) begin
            a = $urandom_range(0, n - 1);
            graph_rows[a] = '0;
            for (i = 0; i < n; i++) graph_rows[i][a] = 1'b0;
        end
        if ($urandom_range(0, 5) == 0) begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            graph_rows[a][b] = !graph_rows[a][b];
        end
        for (i = 0; i < n; i++) graph_rows[i] |= {$urandom, $urandom} & ~span;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0)
                send_item(KIND_LOAD,
                          ($urandom_range(0, 1) != 0) ? 7'd0 : VW'($urandom_range(65, 127)),
                          {$urandom, $urandom}, VW'($urandom));
            send_item(KIND_LOAD, VW'(perm[i] + 1), graph_rows[perm[i]], VW'($urandom));
        end
        for (i = 0; i < starts; i++) begin
            if ($urandom_range(0, 7) == 0)
                root = ($urandom_range(0, 1) != 0) ? '0 : VW'($urandom_range(n + 1, 127));
            else
                root = VW'($urandom_range(1, n));
            send_item(KIND_START, VW'($urandom), {$urandom, $urandom}, root);
            if ($urandom_range(0, 2) == 0)
                wait_results();
        end
    endtask

    task automatic test_load_extremes();
        send_item(KIND_LOAD, 7'd0, '1, '0);
        send_item(KIND_LOAD, 7'd127, '0, 7'd127);
        send_item(KIND_LOAD, 7'd65, 64'hA5A5_5A5A_F0F0_0F0F, '0);
        send_item(KIND_LOAD, 7'd64, '1, '0);
    endtask

    task automatic test_single_vertex();
        write_vertex_count(7'd0);
        send_item(KIND_LOAD, 7'd1, '1, '0);
        send_item(KIND_START, '0, '0, 7'd1);
        send_item(KIND_START, '0, '0, 7'd0);
        send_item(KIND_START, '0, '0, 7'd2);
        write_vertex_count(7'd1);
        send_item(KIND_START, '1, '1, 7'd1);
    endtask

    task automatic test_path_graph();
        write_vertex_count(7'd4);
        send_item(KIND_LOAD, 7'd1, 64'h8000_0000_0000_0002, '0);
        send_item(KIND_LOAD, 7'd2, 64'h0000_0000_0000_0007, '0);
        send_item(KIND_LOAD, 7'd3, 64'h0000_0000_0000_000A, '0);
        send_item(KIND_LOAD, 7'd4, 64'h0000_0000_0000_0004, '0);
        send_item(KIND_START, '0, '0, 7'd1);
        wait_results();
        send_item(KIND_START, '0, '0, 7'd3);
        send_item(KIND_LOAD, 7'd3, 64'h0000_0000_0000_0002, '0);
        send_item(KIND_LOAD, 7'd4, 64'h0000_0000_0000_0000, '0);
        send_item(KIND_START, '0, '0, 7'd1);
        send_item(KIND_START, '0, '0, 7'd4);
    endtask

    task automatic test_count_saturation();
        write_vertex_count(7'd127);
        send_item(KIND_START, '0, '0, 7'd65);
        send_item(KIND_START, '0, '0, 7'd127);
        send_item(KIND_START, '0, '0, 7'd0);
    endtask

    task automatic test_no_idle_stretch();
        write_vertex_count(7'd10);
        @(negedge i_clk);
        no_idle = 1'b1;
        send_graph(10, 1'b1, 3);
        send_graph(10, 1'b0, 2);
        wait_results();
        no_idle = 1'b0;
    endtask

    task automatic test_output_hold();
        write_vertex_count(7'd12);
        @(negedge i_clk);
        hold_req = 1'b1;
        send_graph(12, 1'b1, 2);
    endtask

    task automatic test_random_graphs();
        int            first;
        int            n;
        int            pick;
        logic [VW-1:0] cfg_value;
        first = items_sent;
        write_vertex_count(VW'($urandom_range(64, 127)));
        send_graph(NV, 1'b1, 2);
        while (items_sent - first < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                n = 1;
                cfg_value = VW'($urandom_range(0, 1));
            end else if (pick == 1) begin
                n = $urandom_range(17, 40);
                cfg_value = VW'(n);
            end else begin
                n = $urandom_range(2, 16);
                cfg_value = VW'(n);
            end
            write_vertex_count(cfg_value);
            send_graph(n, $urandom_range(0, 99) < 80, $urandom_range(1, 3));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_load_extremes();
        test_single_vertex();
        test_path_graph();
        test_count_saturation();
        test_no_idle_stretch();
        test_output_hold();
        test_random_graphs();
        wait_idle();
        if (results_due.size() != 0)
            report_mismatch("results never delivered", results_due.size(), 0);
        $display("summary: %0d transactions in, %0d results checked, %0d vertex count writes",
                 items_taken, results_seen, cfg_writes);
        $display("summary: %0d spanning trees and %0d unconnected searches, %0d cycles",
                 trees_predicted, unconnected_predicted, cycle_count);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bfs_pkg.sv
rtl/bfs_ctrl.sv
rtl/bfs_datapath.sv
rtl/bfs_spanning_tree_unit.sv
dv/tb_top.sv
